// ===== rtl/srlbc_pkg.sv =====
// Shared types and constants for the servo rate limit / biquad / clamp block.
// Holds register widths, register indexes, reset values and the config struct.
// No dependencies.
package srlbc_pkg;

	localparam int COEF_W     = 16;
	localparam int LIM_W      = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_IN0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_IN1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_IN2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_OUT1   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_OUT2   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP   = 3'd6;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_in0;
		logic signed [COEF_W-1:0] coef_in1;
		logic signed [COEF_W-1:0] coef_in2;
		logic signed [COEF_W-1:0] coef_out1;
		logic signed [COEF_W-1:0] coef_out2;
		logic        [LIM_W-1:0]  angle_limit;
		logic        [LIM_W-1:0]  rate_step;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		coef_in0:    16'sd2844,
		coef_in1:    16'sd5687,
		coef_in2:    16'sd2844,
		coef_out1:   16'sd8720,
		coef_out2:   16'sd3711,
		angle_limit: 15'd11520,
		rate_step:   15'd512
	};

endpackage

// ===== rtl/servo_rate_limit_biquad_clamp.sv =====
// Steering servo model: rate limiter, biquad filter and angle clamp, top level.
// Takes one word per cycle; a word is registered, then processed in one pass
// (limit against the last angle, five coefficient products, round, saturate,
// clamp) into the result register once that register is free or being
// read. The feedback loop through the previous angle and filter
// history, with its five 16x16 multipliers and clamp, sets the clock period.
// Input ready drops only while a word waits in the input register and the
// result register is full and not being read.
// Depends on srlbc_pkg, srlbc_cfg and srlbc_datapath.
module servo_rate_limit_biquad_clamp #(
	parameter int ANGLE_WIDTH    = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [srlbc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [srlbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [ANGLE_WIDTH-1:0]    cmd_angle,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [ANGLE_WIDTH-1:0]    wheel_angle,
	output logic                             rate_limited,
	output logic                             angle_limited
);

	localparam int AW = ANGLE_WIDTH;

	srlbc_pkg::cfg_t cfg;

	logic                 vld_s1;
	logic signed [AW-1:0] cmd_s1;
	logic                 out_vld_q;
	logic signed [AW-1:0] angle_q;
	logic                 rflag_q, aflag_q;
	logic signed [AW-1:0] last_q, xin1_q, xin2_q, yout1_q, yout2_q;
	logic signed [AW-1:0] x, y, fin;
	logic                 rflag, aflag;
	logic                 advance;

	srlbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	srlbc_datapath #(
		.AW   (AW),
		.FRAC (COEF_FRAC_BITS)
	) u_datapath (
		.cfg   (cfg),
		.cmd   (cmd_s1),
		.last  (last_q),
		.xin1  (xin1_q),
		.xin2  (xin2_q),
		.yout1 (yout1_q),
		.yout2 (yout2_q),
		.x     (x),
		.y     (y),
		.fin   (fin),
		.rflag (rflag),
		.aflag (aflag)
	);

	assign advance  = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			last_q    <= '0;
			xin1_q    <= '0;
			xin2_q    <= '0;
			yout1_q   <= '0;
			yout2_q   <= '0;
		end else begin
			if (advance) begin
				out_vld_q <= 1'b1;
				last_q    <= fin;
				xin1_q    <= x;
				xin2_q    <= xin1_q;
				yout1_q   <= y;
				yout2_q   <= yout1_q;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			angle_q <= fin;
			rflag_q <= rflag;
			aflag_q <= aflag;
		end
	end

	assign out_valid     = out_vld_q;
	assign wheel_angle   = angle_q;
	assign rate_limited  = rflag_q;
	assign angle_limited = aflag_q;

endmodule

// ===== rtl/srlbc_cfg.sv =====
// Configuration register file: coefficients, angle limit and rate step.
// Depends on srlbc_pkg.
module srlbc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [srlbc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [srlbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output srlbc_pkg::cfg_t                  cfg
);

	srlbc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= srlbc_pkg::CFG_RESET;
		end else if (cfg_wen) begin
			case (cfg_idx)
				srlbc_pkg::REG_COEF_IN0:    cfg_q.coef_in0    <= cfg_wdata[srlbc_pkg::COEF_W-1:0];
				srlbc_pkg::REG_COEF_IN1:    cfg_q.coef_in1    <= cfg_wdata[srlbc_pkg::COEF_W-1:0];
				srlbc_pkg::REG_COEF_IN2:    cfg_q.coef_in2    <= cfg_wdata[srlbc_pkg::COEF_W-1:0];
				srlbc_pkg::REG_COEF_OUT1:   cfg_q.coef_out1   <= cfg_wdata[srlbc_pkg::COEF_W-1:0];
				srlbc_pkg::REG_COEF_OUT2:   cfg_q.coef_out2   <= cfg_wdata[srlbc_pkg::COEF_W-1:0];
				srlbc_pkg::REG_ANGLE_LIMIT: cfg_q.angle_limit <= cfg_wdata[srlbc_pkg::LIM_W-1:0];
				srlbc_pkg::REG_RATE_STEP:   cfg_q.rate_step   <= cfg_wdata[srlbc_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/srlbc_datapath.sv =====
// Single-pass datapath: rate limiter, second-order IIR with rounding and
// saturation, and final angle clamp. Depends on srlbc_pkg.
module srlbc_datapath #(
	parameter int AW   = 16,
	parameter int FRAC = 14
) (
	input  srlbc_pkg::cfg_t cfg,
	input  logic signed [AW-1:0] cmd,
	input  logic signed [AW-1:0] last,
	input  logic signed [AW-1:0] xin1,
	input  logic signed [AW-1:0] xin2,
	input  logic signed [AW-1:0] yout1,
	input  logic signed [AW-1:0] yout2,
	output logic signed [AW-1:0] x,
	output logic signed [AW-1:0] y,
	output logic signed [AW-1:0] fin,
	output logic                 rflag,
	output logic                 aflag
);

	localparam int EW    = ((AW > srlbc_pkg::LIM_W) ? AW : srlbc_pkg::LIM_W) + 2;
	localparam int PW    = srlbc_pkg::COEF_W + AW;
	localparam int ACC_W = PW + 3;
	localparam logic signed [ACC_W-1:0] AMAX = {{(ACC_W-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] AMIN = ~AMAX;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC-1);

	logic signed [EW-1:0]    cmd_e, last_e, step_e, lim_e, diff, up, dn, y_e;
	logic signed [PW-1:0]    p0, p1, p2, p3, p4;
	logic signed [ACC_W-1:0] acc, acc_r, ysh;

	always_comb begin
		cmd_e  = EW'(cmd);
		last_e = EW'(last);
		step_e = $signed(EW'(cfg.rate_step));
		lim_e  = $signed(EW'(cfg.angle_limit));
		diff   = cmd_e - last_e;
		up     = last_e + step_e;
		dn     = last_e - step_e;
		x      = cmd;
		rflag  = 1'b0;
		if (diff > step_e) begin
			x     = AW'(up);
			rflag = 1'b1;
		end else if (diff < -step_e) begin
			x     = AW'(dn);
			rflag = 1'b1;
		end
	end

	always_comb begin
		p0    = cfg.coef_in0  * x;
		p1    = cfg.coef_in1  * xin1;
		p2    = cfg.coef_in2  * xin2;
		p3    = cfg.coef_out1 * yout1;
		p4    = cfg.coef_out2 * yout2;
		acc   = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + ACC_W'(p3) - ACC_W'(p4);
		acc_r = acc + HALF;
		ysh   = acc_r >>> FRAC;
		if (ysh > AMAX) begin
			y = AW'(AMAX);
		end else if (ysh < AMIN) begin
			y = AW'(AMIN);
		end else begin
			y = AW'(ysh);
		end
	end

	always_comb begin
		y_e   = EW'(y);
		fin   = y;
		aflag = 1'b0;
		if (y_e > lim_e) begin
			fin   = AW'(lim_e);
			aflag = 1'b1;
		end else if (y_e < -lim_e) begin
			fin   = AW'(-lim_e);
			aflag = 1'b1;
		end
	end

endmodule
